FILE: rtl/sthc_pkg.sv
// Shared types, constants and microprogram for the heading controller.
// Used by sthc_useq and spin_to_heading_controller; depends on nothing.
package sthc_pkg;

    // angle constants, 1/4096 rad
    localparam logic signed [16:0] ANG_PI  = 17'sd12868;
    localparam logic signed [16:0] ANG_2PI = 17'sd25736;

    // result status codes
    localparam logic [1:0] ST_RUNNING   = 2'd0;
    localparam logic [1:0] ST_SUCCEEDED = 2'd1;
    localparam logic [1:0] ST_FAILED    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_RATE   = 3'd0;
    localparam logic [2:0] CFG_MIN_RATE   = 3'd1;
    localparam logic [2:0] CFG_ACCEL      = 3'd2;
    localparam logic [2:0] CFG_GOAL_TOL   = 3'd3;
    localparam logic [2:0] CFG_SETTLE_TOL = 3'd4;

    // configuration reset values
    localparam logic [14:0] RST_MAX_RATE   = 15'd4915;
    localparam logic [14:0] RST_MIN_RATE   = 15'd410;
    localparam logic [15:0] RST_ACCEL      = 16'd1229;
    localparam logic [11:0] RST_GOAL_TOL   = 12'd205;
    localparam logic [11:0] RST_SETTLE_TOL = 12'd4;

    // heading wrap gives up after this many corrections
    localparam logic [1:0] WRAP_MAX = 2'd3;

    localparam int PC_W = 4;

    // datapath operation of one microstep
    typedef enum logic [3:0] {
        UOP_FETCH,
        UOP_WRAP,
        UOP_START,
        UOP_TCHK,
        UOP_DIFF,
        UOP_FOLD,
        UOP_TOL,
        UOP_MUL,
        UOP_SQRT,
        UOP_CLAMP,
        UOP_EMIT
    } t_uop;

    // sequencing of one microstep
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_GOTO,
        COND_FETCH,
        COND_WRAP,
        COND_TIMEOUT,
        COND_INTOL,
        COND_SQRT,
        COND_EMIT
    } t_cond;

    typedef struct packed {
        t_uop            uop;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_accept;
        logic mode;
        logic wrap_more;
        logic timeout;
        logic in_tol;
        logic sqrt_more;
        logic out_free;
    } t_flags;

    // step addresses
    localparam logic [PC_W-1:0] PC_FETCH = 4'd0;
    localparam logic [PC_W-1:0] PC_WRAP  = 4'd1;
    localparam logic [PC_W-1:0] PC_TCHK  = 4'd3;
    localparam logic [PC_W-1:0] PC_SQRT  = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd10;

    // microprogram
    function automatic t_ctrl seq_rom(input logic [PC_W-1:0] pc);
        t_ctrl c;
        begin
            case (pc)
                4'd0:    c = '{UOP_FETCH, COND_FETCH,   PC_TCHK};
                4'd1:    c = '{UOP_WRAP,  COND_WRAP,    PC_WRAP};
                4'd2:    c = '{UOP_START, COND_GOTO,    PC_EMIT};
                4'd3:    c = '{UOP_TCHK,  COND_TIMEOUT, PC_EMIT};
                4'd4:    c = '{UOP_DIFF,  COND_NEXT,    PC_FETCH};
                4'd5:    c = '{UOP_FOLD,  COND_NEXT,    PC_FETCH};
                4'd6:    c = '{UOP_TOL,   COND_INTOL,   PC_EMIT};
                4'd7:    c = '{UOP_MUL,   COND_NEXT,    PC_FETCH};
                4'd8:    c = '{UOP_SQRT,  COND_SQRT,    PC_SQRT};
                4'd9:    c = '{UOP_CLAMP, COND_NEXT,    PC_FETCH};
                4'd10:   c = '{UOP_EMIT,  COND_EMIT,    PC_FETCH};
                default: c = '{UOP_EMIT,  COND_GOTO,    PC_FETCH};
            endcase
            return c;
        end
    endfunction

endpackage

FILE: rtl/sthc_useq.sv
// Microcode sequencer: step counter and control store for the controller.
// Depends on sthc_pkg for the control word, flags and microprogram.
module sthc_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sthc_pkg::t_flags  i_flags,
    output sthc_pkg::t_uop    o_uop
);

    logic [sthc_pkg::PC_W-1:0] r_pc;
    logic [sthc_pkg::PC_W-1:0] n_pc;
    logic [sthc_pkg::PC_W-1:0] w_inc;
    sthc_pkg::t_ctrl           w_ctrl;

    assign w_ctrl = sthc_pkg::seq_rom(r_pc);
    assign w_inc  = r_pc + 1'b1;
    assign o_uop  = w_ctrl.uop;

    // next step address
    always_comb begin
        case (w_ctrl.cond)
            sthc_pkg::COND_NEXT:    n_pc = w_inc;
            sthc_pkg::COND_GOTO:    n_pc = w_ctrl.target;
            sthc_pkg::COND_FETCH: begin
                if (!i_flags.in_accept) n_pc = r_pc;
                else if (i_flags.mode)  n_pc = w_ctrl.target;
                else                    n_pc = w_inc;
            end
            sthc_pkg::COND_WRAP:    n_pc = i_flags.wrap_more ? w_ctrl.target : w_inc;
            sthc_pkg::COND_TIMEOUT: n_pc = i_flags.timeout   ? w_ctrl.target : w_inc;
            sthc_pkg::COND_INTOL:   n_pc = i_flags.in_tol    ? w_ctrl.target : w_inc;
            sthc_pkg::COND_SQRT:    n_pc = i_flags.sqrt_more ? w_ctrl.target : w_inc;
            sthc_pkg::COND_EMIT:    n_pc = i_flags.out_free  ? w_ctrl.target : r_pc;
            default:                n_pc = sthc_pkg::PC_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= sthc_pkg::PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: rtl/spin_to_heading_controller.sv
// Heading controller top level: ports, configuration registers and datapath.
// Depends on sthc_pkg and sthc_useq (microcode sequencer).
// A start passes 1 to 4 wrap steps and the start step. An update passes the timeout check,
// difference, fold and tolerance, then product, 16 square root steps and clamp; a timeout
// or in-tolerance result goes straight to emit. One item in flight; a waiting result holds.
// Synchronous active-low reset restores config defaults and clears the turn state.
module spin_to_heading_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic signed [16:0] i_target_yaw,
    input  logic signed [14:0] i_measured_yaw,
    input  logic [30:0]        i_allowance_ms,
    input  logic [31:0]        i_now_ms,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_turn_rate,
    output logic               o_rate_valid,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    // configuration
    logic [14:0] r_max_rate;
    logic [14:0] r_min_rate;
    logic [15:0] r_accel;
    logic [11:0] r_goal_tol;
    logic [11:0] r_settle_tol;

    // turn state
    logic signed [15:0] r_goal;
    logic signed [15:0] r_last;
    logic [31:0]        r_dead;
    logic               r_ten;

    // captured item
    logic signed [16:0] r_t;
    logic signed [14:0] r_meas;
    logic [30:0]        r_allow;
    logic [31:0]        r_now;
    logic [1:0]         r_wcnt;

    // working registers
    logic [15:0]        r_m;
    logic signed [16:0] r_err;
    logic [15:0]        r_aerr;
    logic [31:0]        r_sn;
    logic [31:0]        r_sr;
    logic [31:0]        r_bit;

    // pending result and output register
    logic [1:0]         r_res_status;
    logic signed [15:0] r_res_rate;
    logic               r_res_rvalid;
    logic               r_ovalid;
    logic [1:0]         r_ostatus;
    logic signed [15:0] r_orate;
    logic               r_orvalid;

    sthc_pkg::t_uop   w_uop;
    sthc_pkg::t_flags w_flags;

    logic               w_in_accept;
    logic               w_out_free;
    logic               w_wrap_big;
    logic signed [16:0] w_meas17;
    logic signed [16:0] w_dyaw;
    logic signed [16:0] w_fold;
    logic [31:0]        w_left;
    logic [31:0]        w_prod;
    logic [31:0]        w_sum;
    logic               w_sq_ge;
    logic [15:0]        w_lo;
    logic [15:0]        w_cl;

    sthc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uop   (w_uop)
    );

    // handshakes
    assign o_stall     = (w_uop != sthc_pkg::UOP_FETCH);
    assign w_in_accept = i_valid && !o_stall;
    assign w_out_free  = !r_ovalid || !i_stall;

    // datapath arithmetic
    assign w_wrap_big = (r_t >= sthc_pkg::ANG_PI) || (r_t <= -sthc_pkg::ANG_PI);
    assign w_meas17   = {{2{r_meas[14]}}, r_meas};
    assign w_dyaw     = w_meas17 - {r_last[15], r_last};
    assign w_fold     = sthc_pkg::ANG_2PI - $signed({1'b0, r_m});
    assign w_left     = r_dead - r_now;
    assign w_prod     = r_accel * r_aerr;
    assign w_sum      = r_sr + r_bit;
    assign w_sq_ge    = (r_sn >= w_sum);
    assign w_lo       = (r_sr[15:0] < {1'b0, r_min_rate}) ? {1'b0, r_min_rate} : r_sr[15:0];
    assign w_cl       = (w_lo > {1'b0, r_max_rate}) ? {1'b0, r_max_rate} : w_lo;

    // status towards the sequencer
    assign w_flags.in_accept = w_in_accept;
    assign w_flags.mode      = i_mode;
    assign w_flags.wrap_more = w_wrap_big && (r_wcnt != sthc_pkg::WRAP_MAX);
    assign w_flags.timeout   = r_ten && w_left[31];
    assign w_flags.in_tol    = (r_aerr < {4'd0, r_goal_tol});
    assign w_flags.sqrt_more = !r_bit[0];
    assign w_flags.out_free  = w_out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate   <= sthc_pkg::RST_MAX_RATE;
            r_min_rate   <= sthc_pkg::RST_MIN_RATE;
            r_accel      <= sthc_pkg::RST_ACCEL;
            r_goal_tol   <= sthc_pkg::RST_GOAL_TOL;
            r_settle_tol <= sthc_pkg::RST_SETTLE_TOL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sthc_pkg::CFG_MAX_RATE:   r_max_rate   <= i_cfg_data[14:0];
                sthc_pkg::CFG_MIN_RATE:   r_min_rate   <= i_cfg_data[14:0];
                sthc_pkg::CFG_ACCEL:      r_accel      <= i_cfg_data;
                sthc_pkg::CFG_GOAL_TOL:   r_goal_tol   <= i_cfg_data[11:0];
                sthc_pkg::CFG_SETTLE_TOL: r_settle_tol <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // turn state, written by start and by non-timed-out updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal <= '0;
            r_last <= '0;
            r_dead <= '0;
            r_ten  <= 1'b0;
        end else begin
            case (w_uop)
                sthc_pkg::UOP_START: begin
                    r_goal <= r_t[15:0];
                    r_last <= w_meas17[15:0];
                    r_dead <= r_now + {1'b0, r_allow};
                    r_ten  <= (r_allow != '0);
                end
                sthc_pkg::UOP_DIFF: begin
                    r_last <= w_meas17[15:0];
                end
                default: ;
            endcase
        end
    end

    // item capture and working registers
    always_ff @(posedge i_clk) begin
        case (w_uop)
            sthc_pkg::UOP_FETCH: begin
                if (w_in_accept) begin
                    r_t     <= i_target_yaw;
                    r_meas  <= i_measured_yaw;
                    r_allow <= i_allowance_ms;
                    r_now   <= i_now_ms;
                    r_wcnt  <= '0;
                end
            end
            sthc_pkg::UOP_WRAP: begin
                if (w_flags.wrap_more) begin
                    r_t    <= r_t[16] ? r_t + sthc_pkg::ANG_2PI : r_t - sthc_pkg::ANG_2PI;
                    r_wcnt <= r_wcnt + 1'b1;
                end
            end
            sthc_pkg::UOP_START: begin
                r_res_status <= sthc_pkg::ST_RUNNING;
                r_res_rate   <= '0;
                r_res_rvalid <= 1'b0;
            end
            sthc_pkg::UOP_TCHK: begin
                r_res_status <= sthc_pkg::ST_FAILED;
                r_res_rate   <= '0;
                r_res_rvalid <= 1'b1;
            end
            sthc_pkg::UOP_DIFF: begin
                r_m   <= w_dyaw[16] ? 16'(-w_dyaw) : w_dyaw[15:0];
                r_err <= {r_goal[15], r_goal} - w_meas17;
            end
            sthc_pkg::UOP_FOLD: begin
                // yaw change past half a turn is measured the other way round
                if (r_m > 16'(sthc_pkg::ANG_PI)) begin
                    r_m <= w_fold[16] ? 16'(-w_fold) : w_fold[15:0];
                end
                r_aerr <= r_err[16] ? 16'(-r_err) : r_err[15:0];
            end
            sthc_pkg::UOP_TOL: begin
                r_res_status <= (r_m < {4'd0, r_settle_tol}) ? sthc_pkg::ST_SUCCEEDED
                                                             : sthc_pkg::ST_RUNNING;
                r_res_rate   <= '0;
                r_res_rvalid <= 1'b1;
            end
            sthc_pkg::UOP_MUL: begin
                r_sn  <= {w_prod[30:0], 1'b0};
                r_sr  <= '0;
                r_bit <= 32'h4000_0000;
            end
            sthc_pkg::UOP_SQRT: begin
                // one result bit per step, restoring form
                if (w_sq_ge) begin
                    r_sn <= r_sn - w_sum;
                    r_sr <= (r_sr >> 1) + r_bit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            sthc_pkg::UOP_CLAMP: begin
                r_res_status <= sthc_pkg::ST_RUNNING;
                r_res_rate   <= r_err[16] ? $signed(16'd0 - w_cl) : $signed(w_cl);
                r_res_rvalid <= 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_uop == sthc_pkg::UOP_EMIT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uop == sthc_pkg::UOP_EMIT && w_out_free) begin
            r_ostatus <= r_res_status;
            r_orate   <= r_res_rate;
            r_orvalid <= r_res_rvalid;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_turn_rate  = r_orate;
    assign o_rate_valid = r_orvalid;

endmodule

FILE: tb/spin_to_heading_controller_test.sv
// Self-checking testbench for spin_to_heading_controller: directed corner cases,
// then randomised turn sequences checked against an in-bench heading predictor.
// Depends on sthc_pkg and the controller RTL.
module spin_to_heading_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit        MODE_START   = 1'b0;
    localparam bit        MODE_UPDATE  = 1'b1;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;
    localparam int        HALF_TURN    = sthc_pkg::ANG_PI;
    localparam int        FULL_TURN    = sthc_pkg::ANG_2PI;
    localparam int        DRAIN_CYCLES = 32;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]         status;
        logic signed [15:0] turn_rate;
        logic               rate_valid;
    } t_heading_cmd;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_mode = 1'b0;
    logic signed [16:0] i_target_yaw = '0;
    logic signed [14:0] i_measured_yaw = '0;
    logic [30:0]        i_allowance_ms = '0;
    logic [31:0]        i_now_ms = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic signed [15:0] o_turn_rate;
    logic               o_rate_valid;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;

    // register mirror
    logic [14:0] cfg_max_rate   = sthc_pkg::RST_MAX_RATE;
    logic [14:0] cfg_min_rate   = sthc_pkg::RST_MIN_RATE;
    logic [15:0] cfg_accel      = sthc_pkg::RST_ACCEL;
    logic [11:0] cfg_goal_tol   = sthc_pkg::RST_GOAL_TOL;
    logic [11:0] cfg_settle_tol = sthc_pkg::RST_SETTLE_TOL;

    // controller state mirror
    int          goal_hd = 0;
    int          prev_yaw = 0;
    logic [31:0] deadline_ms = '0;
    bit          deadline_armed = 1'b0;

    t_heading_cmd pending_cmds[$];
    int unsigned  err_count = 0;
    int unsigned  items_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  cycle_count = 0;
    bit           idle_en = 1'b1;
    logic [31:0]  sim_now = '0;

    spin_to_heading_controller uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_target_yaw   (i_target_yaw),
        .i_measured_yaw (i_measured_yaw),
        .i_allowance_ms (i_allowance_ms),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_turn_rate    (o_turn_rate),
        .o_rate_valid   (o_rate_valid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic int wrap_heading(int t);
        while (t >= HALF_TURN || t <= -HALF_TURN)
            t = (t > 0) ? t - FULL_TURN : t + FULL_TURN;
        return t;
    endfunction

    // floor square root, one result bit at a time from the top
    function automatic longint floor_sqrt(longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root + (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic t_heading_cmd predict_heading_cmd(bit mode, logic signed [16:0] tgt,
            logic signed [14:0] meas, logic [30:0] allow, logic [31:0] now);
        t_heading_cmd cmd;
        int           yaw;
        int           change;
        int           err;
        int           mag;
        longint       rate_mag;
        logic [31:0]  slack;
        cmd.status = sthc_pkg::ST_RUNNING;
        cmd.turn_rate = '0;
        cmd.rate_valid = 1'b0;
        yaw = meas;
        if (mode == MODE_START) begin
            goal_hd = wrap_heading(tgt);
            prev_yaw = yaw;
            deadline_ms = now + {1'b0, allow};
            deadline_armed = (allow != '0);
        end else begin
            slack = deadline_ms - now;
            cmd.rate_valid = 1'b1;
            if (deadline_armed && slack[31]) begin
                cmd.status = sthc_pkg::ST_FAILED;
            end else begin
                change = (yaw > prev_yaw) ? yaw - prev_yaw : prev_yaw - yaw;
                if (change > HALF_TURN)
                    change = (FULL_TURN > change) ? FULL_TURN - change : change - FULL_TURN;
                err = goal_hd - yaw;
                mag = (err < 0) ? -err : err;
                prev_yaw = yaw;
                if (mag < int'(cfg_goal_tol)) begin
                    cmd.status = (change < int'(cfg_settle_tol)) ? sthc_pkg::ST_SUCCEEDED
                                                                 : sthc_pkg::ST_RUNNING;
                end else begin
                    rate_mag = floor_sqrt(longint'(cfg_accel) * 2 * mag);
                    if (rate_mag < longint'(cfg_min_rate)) rate_mag = cfg_min_rate;
                    if (rate_mag > longint'(cfg_max_rate)) rate_mag = cfg_max_rate;
                    cmd.turn_rate = 16'((err < 0) ? -rate_mag : rate_mag);
                end
            end
        end
        return cmd;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string what, int got, int want);
        if (err_count < 200)
            $display("mismatch on %0s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
        err_count++;
    endtask

    // outputs settle after the rising edge, so the falling edge sees what transfers next
    always @(negedge i_clk) begin
        t_heading_cmd want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_cmds.size() == 0) begin
                flag_mismatch("unexpected result", o_status, -1);
            end else begin
                want = pending_cmds.pop_front();
                if (o_status !== want.status)
                    flag_mismatch("status", o_status, want.status);
                if (o_turn_rate !== want.turn_rate)
                    flag_mismatch("turn_rate", o_turn_rate, want.turn_rate);
                if (o_rate_valid !== want.rate_valid)
                    flag_mismatch("rate_valid", o_rate_valid, want.rate_valid);
            end
            results_seen++;
        end
    end

    // result-side back-pressure: random bursts of stalled cycles between quiet runs
    int unsigned stall_left = 0;
    int unsigned quiet_left = 0;
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (quiet_left != 0) begin
            quiet_left <= quiet_left - 1;
            i_stall <= 1'b0;
        end else if (idle_en && $urandom_range(4) == 0) begin
            stall_left <= $urandom_range(17, 0);
            quiet_left <= $urandom_range(60, 0);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- driving

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // a heading exactly at pi (mod 2 pi) alternates between the two ends when wrapped
    function automatic int steer_off_pi(int t);
        if ((((t % FULL_TURN) + FULL_TURN) % FULL_TURN) == HALF_TURN)
            return t + 1;
        return t;
    endfunction

    // one transfer on the input channel; called and returns at a rising edge
    task automatic send_item(bit mode, int tgt, int yaw, logic [30:0] allow, logic [31:0] now);
        bit taken;
        if (idle_en && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_target_yaw <= 17'(tgt);
        i_measured_yaw <= 15'(yaw);
        i_allowance_ms <= allow;
        i_now_ms <= now;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        pending_cmds.push_back(predict_heading_cmd(mode, 17'(tgt), 15'(yaw), allow, now));
        items_sent++;
    endtask

    // drop valid, let every result arrive, then allow for work still in flight
    task automatic wait_until_idle();
        i_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sthc_pkg::CFG_MAX_RATE:   cfg_max_rate = data[14:0];
            sthc_pkg::CFG_MIN_RATE:   cfg_min_rate = data[14:0];
            sthc_pkg::CFG_ACCEL:      cfg_accel = data;
            sthc_pkg::CFG_GOAL_TOL:   cfg_goal_tol = data[11:0];
            sthc_pkg::CFG_SETTLE_TOL: cfg_settle_tol = data[11:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    // wrap of large commands and the yaw-change fold, reset configuration
    task automatic test_heading_wrap();
        send_item(MODE_START, 65535, 0, '0, 32'd0);
        send_item(MODE_UPDATE, 0, 0, '0, 32'd5);
        send_item(MODE_START, -65536, -16384, '0, 32'd7);
        send_item(MODE_UPDATE, 0, 16383, '0, 32'd9);
        send_item(MODE_START, 12869, 12867, '0, 32'd11);
        send_item(MODE_UPDATE, 0, 12860, '0, 32'd13);
    endtask

    // deadline edge, wrap of the time stamp and the largest allowance
    task automatic test_deadline();
        send_item(MODE_START, 0, 0, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_UPDATE, 0, 50, '0, 32'd0);
        send_item(MODE_START, 100, 0, 31'd10, 32'd1000);
        send_item(MODE_UPDATE, 0, 10, '0, 32'd1010);
        send_item(MODE_UPDATE, 0, 20, '0, 32'd1011);
        send_item(MODE_START, 0, -12868, 31'd1, 32'd0);
        send_item(MODE_UPDATE, 0, -12868, '0, 32'd2);
    endtask

    // arrival inside the goal band, settled and still moving
    task automatic test_tolerance();
        send_item(MODE_START, -12869, 12800, '0, 32'd3000);
        send_item(MODE_UPDATE, 0, 12800, '0, 32'd3001);
        send_item(MODE_UPDATE, 0, 12700, '0, 32'd3002);
        send_item(MODE_UPDATE, 0, 12700, '0, 32'd3003);
    endtask

    // register extremes: zero band, crossed clamps, full and zero acceleration
    task automatic test_register_corners();
        wait_until_idle();
        write_reg(sthc_pkg::CFG_GOAL_TOL, 16'd0);
        send_item(MODE_START, 100, 100, '0, 32'd4000);
        send_item(MODE_UPDATE, 0, 100, '0, 32'd4001);
        wait_until_idle();
        write_reg(sthc_pkg::CFG_MIN_RATE, 16'd32767);
        write_reg(sthc_pkg::CFG_MAX_RATE, 16'd0);
        send_item(MODE_UPDATE, 0, -16384, '0, 32'd4002);
        wait_until_idle();
        write_reg(sthc_pkg::CFG_MAX_RATE, 16'd32767);
        write_reg(sthc_pkg::CFG_MIN_RATE, 16'd0);
        write_reg(sthc_pkg::CFG_ACCEL, 16'd65535);
        send_item(MODE_START, -12867, 16383, '0, 32'd4003);
        send_item(MODE_UPDATE, 0, 16383, '0, 32'd4004);
        wait_until_idle();
        write_reg(sthc_pkg::CFG_ACCEL, 16'd0);
        send_item(MODE_UPDATE, 0, 0, '0, 32'd4005);
        wait_until_idle();
        write_reg(sthc_pkg::CFG_GOAL_TOL, 16'd4095);
        write_reg(sthc_pkg::CFG_SETTLE_TOL, 16'd4095);
        send_item(MODE_UPDATE, 0, -10000, '0, 32'd4006);
        send_item(MODE_UPDATE, 0, -10001, '0, 32'd4007);
        wait_until_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(sthc_pkg::CFG_SETTLE_TOL, 16'd0);
        send_item(MODE_UPDATE, 0, -10001, '0, 32'd4008);
    endtask

    function automatic logic [15:0] pick_value(int lo, int hi, int typ_lo, int typ_hi);
        case ($urandom_range(7))
            0:       return 16'(lo);
            1:       return 16'(hi);
            2:       return 16'($urandom);
            default: return 16'(rand_in(typ_lo, typ_hi));
        endcase
    endfunction

    task automatic randomise_config();
        wait_until_idle();
        write_reg(sthc_pkg::CFG_MAX_RATE, pick_value(0, 32767, 1500, 9000));
        write_reg(sthc_pkg::CFG_MIN_RATE, pick_value(0, 32767, 0, 900));
        write_reg(sthc_pkg::CFG_ACCEL, pick_value(0, 65535, 200, 6000));
        write_reg(sthc_pkg::CFG_GOAL_TOL, pick_value(0, 4095, 0, 600));
        write_reg(sthc_pkg::CFG_SETTLE_TOL, pick_value(0, 4095, 0, 40));
    endtask

    // start commands followed by odometry that mostly closes on the goal
    task automatic test_random_turns(int n_items);
        int          tgt;
        int          yaw;
        int          goal;
        int          err;
        int          stop_at;
        logic [30:0] allow;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                // stray item with every field random
                send_item(1'($urandom_range(1)), steer_off_pi(rand_in(-65536, 65535)),
                          rand_in(-16384, 16383), 31'($urandom), $urandom);
            end else begin
                tgt = ($urandom_range(3) == 0) ? rand_in(-65536, 65535) : rand_in(-12867, 12867);
                tgt = steer_off_pi(tgt);
                goal = wrap_heading(tgt);
                yaw = rand_in(-12868, 12868);
                case ($urandom_range(3))
                    0:       allow = '0;
                    1:       allow = 31'($urandom_range(1500, 1));
                    2:       allow = 31'($urandom_range(200, 1));
                    default: allow = 31'($urandom);
                endcase
                if ($urandom_range(7) == 0)
                    sim_now = $urandom;
                send_item(MODE_START, tgt, yaw, allow, sim_now);
                repeat ($urandom_range(16, 2)) begin
                    sim_now = sim_now + $urandom_range(150, 1);
                    err = goal - yaw;
                    case ($urandom_range(9))
                        0:       yaw = rand_in(-16384, 16383);  // odometry glitch
                        1:       ;                              // no motion
                        default: yaw = yaw + err * int'($urandom_range(8, 1)) / 8 + rand_in(-4, 4);
                    endcase
                    if (yaw > 16383) yaw = 16383;
                    if (yaw < -16384) yaw = -16384;
                    send_item(MODE_UPDATE, rand_in(-65536, 65535), yaw, 31'($urandom), sim_now);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_heading_wrap();
        test_deadline();
        test_tolerance();
        test_register_corners();

        repeat (5) begin
            randomise_config();
            test_random_turns(300);
        end
        // closing stretch at full throughput
        idle_en = 1'b0;
        randomise_config();
        test_random_turns(250);

        wait_until_idle();
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
